/* design/ccr_pkg.sv */
package ccr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int N_W        = $clog2(MAX_POINTS + 1);
  localparam int COUNT_W    = 7;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

  // pipeline depths of the arithmetic units
  localparam int SQRT_STAGES = 16;
  localparam int DIV_STAGES  = 29;
  localparam int HERM_STAGES = 6;

  // knot spacing, divider and tangent widths
  localparam int DT_W  = 25;
  localparam int DEN_W = 26;
  localparam int NUM_W = 2 * DIV_STAGES;
  localparam int TAN_W = 42;
  localparam logic [DT_W-1:0] DT_MIN = 25'd7;
  localparam logic [DT_W-1:0] DT_ONE = 25'd65536;
  localparam longint TAN_LIMIT = 64'sd1 <<< 40;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] res;
  } sqrt_st_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
  } div_st_t;

  // tangent differences, both axes
  typedef struct packed {
    logic signed [32:0] x10;
    logic signed [32:0] x20;
    logic signed [32:0] x31;
    logic signed [32:0] x32;
    logic signed [32:0] y10;
    logic signed [32:0] y20;
    logic signed [32:0] y31;
    logic signed [32:0] y32;
  } diff_t;

  // values carried through to the cubic
  typedef struct packed {
    logic        [15:0] w;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [32:0] x21;
    logic signed [32:0] y21;
  } side_t;

endpackage

/* design/ccr_ram.sv */
module ccr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/ccr_sqrt.sv */
module ccr_sqrt import ccr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  // two result bits per stage
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] b);
    logic [35:0] r2;
    logic [35:0] tr;
    sqrt_st_t    o;
    r2 = {s.rem, b};
    tr = {2'b00, s.res, 2'b01};
    if (r2 >= tr) begin
      o.rem = 34'(r2 - tr);
      o.res = {s.res[30:0], 1'b1};
    end else begin
      o.rem = r2[33:0];
      o.res = {s.res[30:0], 1'b0};
    end
    return o;
  endfunction

  sqrt_st_t    st  [SQRT_STAGES];
  logic [63:0] rad [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    sqrt_st_t    s_in;
    logic [63:0] r_in;
    sqrt_st_t    s_mid;

    if (k == 0) begin : g_head
      assign s_in = '0;
      assign r_in = radicand;
    end else begin : g_tail
      assign s_in = st[k-1];
      assign r_in = rad[k-1];
    end

    assign s_mid = sqrt_step(s_in, r_in[63:62]);

    always_ff @(posedge clk) begin
      if (en) begin
        st[k]  <= sqrt_step(s_mid, r_in[61:60]);
        rad[k] <= {r_in[59:0], 4'b0000};
      end
    end
  end

  assign root = st[SQRT_STAGES-1].res;

endmodule

/* design/ccr_div.sv */
module ccr_div import ccr_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // restoring division, quotient bits shift in behind the dividend
  function automatic div_st_t div_step(div_st_t s, logic [DEN_W-1:0] d);
    logic [DEN_W:0] r2;
    div_st_t        o;
    r2 = {s.rem, s.num[NUM_W-1]};
    if (r2 >= {1'b0, d}) begin
      o.rem = DEN_W'(r2 - {1'b0, d});
      o.num = {s.num[NUM_W-2:0], 1'b1};
    end else begin
      o.rem = r2[DEN_W-1:0];
      o.num = {s.num[NUM_W-2:0], 1'b0};
    end
    return o;
  endfunction

  div_st_t          st   [DIV_STAGES];
  logic [DEN_W-1:0] den_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_st_t          s_in;
    logic [DEN_W-1:0] d_in;
    div_st_t          s_mid;

    if (k == 0) begin : g_head
      assign s_in = {{DEN_W{1'b0}}, num};
      assign d_in = den;
    end else begin : g_tail
      assign s_in = st[k-1];
      assign d_in = den_q[k-1];
    end

    assign s_mid = div_step(s_in, d_in);

    always_ff @(posedge clk) begin
      if (en) begin
        st[k]    <= div_step(s_mid, d_in);
        den_q[k] <= d_in;
      end
    end
  end

  assign quo = st[DIV_STAGES-1].num;

endmodule

/* design/ccr_hermite.sv */
module ccr_hermite import ccr_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] qa,
  input  logic signed [NUM_W-1:0] qb,
  input  logic signed [NUM_W-1:0] qc,
  input  logic signed [NUM_W-1:0] qd,
  input  logic signed [32:0]      x21,
  input  logic signed [31:0]      x1,
  input  logic        [15:0]      w,
  output logic signed [31:0]      res
);

  localparam int T_W = NUM_W + 2;
  localparam int C_W = 44;
  localparam int H_W = 48;
  localparam int P_W = 64;

  logic signed [T_W-1:0] t1, t2;
  logic signed [TAN_W-1:0] m1_n, m2_n;

  logic signed [TAN_W-1:0] s1_m1, s1_m2;
  logic signed [32:0]      s1_x21;
  logic signed [31:0]      s1_x1, s2_x1, s3_x1, s4_x1, s5_x1;
  logic        [15:0]      s1_w, s2_w, s3_w, s4_w;
  logic signed [C_W-1:0]   s2_c2, s2_c3, s3_c2;
  logic signed [TAN_W-1:0] s2_m1, s3_m1, s4_m1;
  logic signed [P_W-1:0]   s3_p, s4_p, s5_p;
  logic signed [H_W-1:0]   h4, h5, h6;
  logic signed [31:0]      res_n;

  function automatic logic signed [TAN_W-1:0] tan_sat(logic signed [T_W-1:0] t);
    if (t > T_W'(TAN_LIMIT)) begin
      return TAN_W'(TAN_LIMIT);
    end else if (t < -T_W'(TAN_LIMIT)) begin
      return -TAN_W'(TAN_LIMIT);
    end
    return TAN_W'(t);
  endfunction

  function automatic logic signed [P_W-1:0] mul_w(logic signed [H_W-1:0] h,
                                                  logic [15:0] f);
    return P_W'(h) * P_W'($signed({1'b0, f}));
  endfunction

  always_comb begin
    t1   = T_W'(qa) - T_W'(qb) + T_W'(x21);
    t2   = T_W'(x21) - T_W'(qc) + T_W'(qd);
    m1_n = tan_sat(t1);
    m2_n = tan_sat(t2);
    h4   = H_W'(s3_p >>> 16) + H_W'(s3_c2);
    h5   = H_W'(s4_p >>> 16) + H_W'(s4_m1);
    h6   = H_W'(s5_p >>> 16) + H_W'(s5_x1);
    if (h6 > H_W'(32'sh7fffffff)) begin
      res_n = 32'sh7fffffff;
    end else if (h6 < -H_W'(32'sh7fffffff) - H_W'(1)) begin
      res_n = 32'sh80000000;
    end else begin
      res_n = 32'(h6);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // tangents
      s1_m1  <= m1_n;
      s1_m2  <= m2_n;
      s1_x21 <= x21;
      s1_x1  <= x1;
      s1_w   <= w;
      // cubic coefficients
      s2_c2 <= C_W'(s1_x21) + C_W'(s1_x21) + C_W'(s1_x21)
             - (C_W'(s1_m1) <<< 1) - C_W'(s1_m2);
      s2_c3 <= C_W'(s1_m1) + C_W'(s1_m2) - (C_W'(s1_x21) <<< 1);
      s2_m1 <= s1_m1;
      s2_x1 <= s1_x1;
      s2_w  <= s1_w;
      // Horner, one multiply a stage
      s3_p  <= mul_w(H_W'(s2_c3), s2_w);
      s3_c2 <= s2_c2;
      s3_m1 <= s2_m1;
      s3_x1 <= s2_x1;
      s3_w  <= s2_w;
      s4_p  <= mul_w(h4, s3_w);
      s4_m1 <= s3_m1;
      s4_x1 <= s3_x1;
      s4_w  <= s3_w;
      s5_p  <= mul_w(h5, s4_w);
      s5_x1 <= s4_x1;
      res   <= res_n;
    end
  end

endmodule

/* design/centripetal_catmull_rom_eval.sv */
// Channel  Dir  Handshake           Word
// in       in   in_valid/in_stall   operation, point_index, point_x, point_y, curve_param
// out      out  out_valid/out_stall curve_x, curve_y
// cfg      in   cfg_valid/cfg_ready cfg_data (point count)
//
// One word a cycle while in_stall is low. An evaluate word passes through the two chained
// square-root pipelines (16 stages each) and the divider pipeline (29 stages, two quotient
// bits a stage) before out_valid rises for it.
// A write word lands in the point store at acceptance and gives no result.
// Reset clears the valid bits and sets the point count to 4; the store is not cleared.
// A stalled output fills a skid register; only when that is full does in_stall rise.
module centripetal_catmull_rom_eval import ccr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic        [5:0]  point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [23:0] curve_param,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] curve_x,
  output logic signed [31:0] curve_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  // stage numbering of the pipeline
  localparam int ST_B       = 1;
  localparam int ST_C       = 2;
  localparam int ST_D       = 3;
  localparam int ST_E       = 4;
  localparam int ST_SQA     = ST_E + SQRT_STAGES;
  localparam int ST_SQB     = ST_SQA + SQRT_STAGES;
  localparam int ST_F       = ST_SQB + 1;
  localparam int ST_G       = ST_F + 1;
  localparam int ST_DIV     = ST_G + DIV_STAGES;
  localparam int PIPE_DEPTH = ST_DIV + HERM_STAGES + 1;

  function automatic logic [32:0] mag33(logic signed [32:0] d);
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic en;
  logic accept;
  logic [COUNT_W-1:0] count;
  logic [N_W-1:0]     n_eff;
  logic [N_W+15:0]    prod;
  logic               wr_ok;

  logic [PIPE_DEPTH-1:0] vld;

  // skid and output registers
  logic               ov, sv;
  logic signed [31:0] ox, oy, sx, sy;
  logic signed [31:0] res_x, res_y;

  assign en        = !sv;
  assign in_stall  = !en;
  assign accept    = in_valid && en;
  assign cfg_ready = 1'b1;
  assign out_valid = ov;
  assign curve_x   = ox;
  assign curve_y   = oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_RESET;
    end else if (cfg_valid) begin
      count <= cfg_data;
    end
  end

  // count 0 acts as one point, counts above the store size are clamped
  always_comb begin
    if (count == '0) begin
      n_eff = N_W'(1);
    end else if (32'(count) > MAX_POINTS) begin
      n_eff = N_W'(MAX_POINTS);
    end else begin
      n_eff = N_W'(count);
    end
    // the integer part of the parameter is a whole number of loops, so the
    // segment is n * frac >> 16 and the fraction is its low half
    prod  = {16'b0, n_eff} * {{N_W{1'b0}}, curve_param[15:0]};
    wr_ok = 32'(point_index) < MAX_POINTS;
  end

  // stage A: segment and fraction
  logic [IDX_W-1:0] a_r;
  logic [15:0]      a_w, b_w;
  logic [N_W-1:0]   a_n;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= prod[IDX_W+15:16];
      a_w <= prod[15:0];
      a_n <= n_eff;
      b_w <= a_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_valid && operation};
    end
  end

  // neighbour indices, wrapped round the closed curve
  logic [N_W:0]       rr, nn, s2, s3, t3;
  logic [IDX_W-1:0]   raddr [4];
  logic [63:0]        ram_rd [4];

  always_comb begin
    rr = (N_W+1)'(a_r);
    nn = (N_W+1)'(a_n);
    s2 = rr + (N_W+1)'(1);
    s3 = rr + (N_W+1)'(2);
    t3 = s3 - nn;
    raddr[0] = (rr == '0) ? IDX_W'(nn - (N_W+1)'(1)) : IDX_W'(rr - (N_W+1)'(1));
    raddr[1] = IDX_W'(rr);
    raddr[2] = (s2 >= nn) ? IDX_W'(s2 - nn) : IDX_W'(s2);
    if (s3 < nn) begin
      raddr[3] = IDX_W'(s3);
    end else if (t3 >= nn) begin
      raddr[3] = IDX_W'(t3 - nn);
    end else begin
      raddr[3] = IDX_W'(t3);
    end
  end

  // one copy of the store per neighbour, all written together
  for (genvar k = 0; k < 4; k++) begin : g_store
    ccr_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_store (
      .clk  (clk),
      .we   (accept && !operation && wr_ok),
      .waddr(IDX_W'(point_index)),
      .wdata({point_x, point_y}),
      .re   (en),
      .raddr(raddr[k]),
      .rdata(ram_rd[k])
    );
  end

  // stage B: point differences
  logic signed [31:0] xs [4];
  logic signed [31:0] ys [4];
  diff_t diff_n;
  side_t side_n;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xs[k] = ram_rd[k][63:32];
      ys[k] = ram_rd[k][31:0];
    end
    diff_n.x10 = 33'(xs[1]) - 33'(xs[0]);
    diff_n.x20 = 33'(xs[2]) - 33'(xs[0]);
    diff_n.x31 = 33'(xs[3]) - 33'(xs[1]);
    diff_n.x32 = 33'(xs[3]) - 33'(xs[2]);
    diff_n.y10 = 33'(ys[1]) - 33'(ys[0]);
    diff_n.y20 = 33'(ys[2]) - 33'(ys[0]);
    diff_n.y31 = 33'(ys[3]) - 33'(ys[1]);
    diff_n.y32 = 33'(ys[3]) - 33'(ys[2]);
    side_n.w   = b_w;
    side_n.x1  = xs[1];
    side_n.y1  = ys[1];
    side_n.x21 = 33'(xs[2]) - 33'(xs[1]);
    side_n.y21 = 33'(ys[2]) - 33'(ys[1]);
  end

  // delay lines that run beside the arithmetic
  diff_t      diff_q [ST_C:ST_F];
  side_t      side_q [ST_C:ST_DIV];
  logic [2:0] sh_q   [ST_D:ST_SQA];
  logic [7:0] sgn_q  [ST_G:ST_DIV];

  // stage C: halve wide differences so the squares fit
  logic signed [32:0] pdx [3];
  logic signed [32:0] pdy [3];
  logic [32:0]        ux, uy;
  logic [31:0]        pa_n [3];
  logic [31:0]        pb_n [3];
  logic [2:0]         sh_n;

  always_comb begin
    pdx[0] = diff_q[ST_C].x10;
    pdx[1] = side_q[ST_C].x21;
    pdx[2] = diff_q[ST_C].x32;
    pdy[0] = diff_q[ST_C].y10;
    pdy[1] = side_q[ST_C].y21;
    pdy[2] = diff_q[ST_C].y32;
    ux = '0;
    uy = '0;
    for (int k = 0; k < 3; k++) begin
      ux      = mag33(pdx[k]);
      uy      = mag33(pdy[k]);
      sh_n[k] = ux[32] | ux[31] | uy[32] | uy[31];
      pa_n[k] = sh_n[k] ? ux[32:1] : ux[31:0];
      pb_n[k] = sh_n[k] ? uy[32:1] : uy[31:0];
    end
  end

  // stage D holds the halves, stage E the sums of squares
  logic [31:0] pa [3];
  logic [31:0] pb [3];
  logic [63:0] sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      diff_q[ST_C] <= diff_n;
      side_q[ST_C] <= side_n;
      for (int k = ST_C + 1; k <= ST_F; k++) begin
        diff_q[k] <= diff_q[k-1];
      end
      for (int k = ST_C + 1; k <= ST_DIV; k++) begin
        side_q[k] <= side_q[k-1];
      end
      sh_q[ST_D] <= sh_n;
      for (int k = ST_D + 1; k <= ST_SQA; k++) begin
        sh_q[k] <= sh_q[k-1];
      end
      for (int k = 0; k < 3; k++) begin
        pa[k] <= pa_n[k];
        pb[k] <= pb_n[k];
        sq[k] <= 64'(pa[k]) * 64'(pa[k]) + 64'(pb[k]) * 64'(pb[k]);
      end
    end
  end

  // distance, then knot spacing as the root of the distance
  logic [31:0] root_a [3];
  logic [31:0] root_b [3];

  for (genvar k = 0; k < 3; k++) begin : g_spacing
    ccr_sqrt u_dist (
      .clk     (clk),
      .en      (en),
      .radicand(sq[k]),
      .root    (root_a[k])
    );
    ccr_sqrt u_knot (
      .clk     (clk),
      .en      (en),
      .radicand(64'(root_a[k]) << (16 + 32'(sh_q[ST_SQA][k]))),
      .root    (root_b[k])
    );
  end

  // stage F: replace spacings that are too short
  logic [DT_W-1:0] dt0, dt1, dt2, fd0, fd1, fd2;

  always_comb begin
    dt1 = (root_b[1][DT_W-1:0] < DT_MIN) ? DT_ONE : root_b[1][DT_W-1:0];
    dt0 = (root_b[0][DT_W-1:0] < DT_MIN) ? dt1 : root_b[0][DT_W-1:0];
    dt2 = (root_b[2][DT_W-1:0] < DT_MIN) ? dt1 : root_b[2][DT_W-1:0];
  end

  // stage G: scaled numerators and the four divisors
  logic signed [32:0] tdiff [8];
  logic [NUM_W-1:0]   num_n [8];
  logic [DEN_W-1:0]   den_n [8];
  logic [7:0]         sgn_n;
  logic [NUM_W-1:0]   num   [8];
  logic [DEN_W-1:0]   den   [8];

  always_comb begin
    tdiff[0] = diff_q[ST_F].x10;
    tdiff[1] = diff_q[ST_F].x20;
    tdiff[2] = diff_q[ST_F].x31;
    tdiff[3] = diff_q[ST_F].x32;
    tdiff[4] = diff_q[ST_F].y10;
    tdiff[5] = diff_q[ST_F].y20;
    tdiff[6] = diff_q[ST_F].y31;
    tdiff[7] = diff_q[ST_F].y32;
    for (int k = 0; k < 8; k++) begin
      sgn_n[k] = tdiff[k][32];
      num_n[k] = NUM_W'(fd1) * NUM_W'(mag33(tdiff[k]));
    end
    for (int a = 0; a < 2; a++) begin
      den_n[4*a]   = DEN_W'(fd0);
      den_n[4*a+1] = DEN_W'(fd0) + DEN_W'(fd1);
      den_n[4*a+2] = DEN_W'(fd1) + DEN_W'(fd2);
      den_n[4*a+3] = DEN_W'(fd2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd0 <= dt0;
      fd1 <= dt1;
      fd2 <= dt2;
      num <= num_n;
      den <= den_n;
      sgn_q[ST_G] <= sgn_n;
      for (int k = ST_G + 1; k <= ST_DIV; k++) begin
        sgn_q[k] <= sgn_q[k-1];
      end
    end
  end

  // quotients truncate toward zero: divide magnitudes, then restore the sign
  logic [NUM_W-1:0]        quo  [8];
  logic signed [NUM_W-1:0] squo [8];

  for (genvar k = 0; k < 8; k++) begin : g_div
    ccr_div u_div (
      .clk(clk),
      .en (en),
      .num(num[k]),
      .den(den[k]),
      .quo(quo[k])
    );
    assign squo[k] = sgn_q[ST_DIV][k] ? -$signed(quo[k]) : $signed(quo[k]);
  end

  ccr_hermite u_herm_x (
    .clk(clk),
    .en (en),
    .qa (squo[0]),
    .qb (squo[1]),
    .qc (squo[2]),
    .qd (squo[3]),
    .x21(side_q[ST_DIV].x21),
    .x1 (side_q[ST_DIV].x1),
    .w  (side_q[ST_DIV].w),
    .res(res_x)
  );

  ccr_hermite u_herm_y (
    .clk(clk),
    .en (en),
    .qa (squo[4]),
    .qb (squo[5]),
    .qc (squo[6]),
    .qd (squo[7]),
    .x21(side_q[ST_DIV].y21),
    .x1 (side_q[ST_DIV].y1),
    .w  (side_q[ST_DIV].w),
    .res(res_y)
  );

  // output register with a skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (!out_stall) begin
        ox <= sx;
        oy <= sy;
        sv <= 1'b0;
      end
    end else if (vld[PIPE_DEPTH-1]) begin
      if (!ov || !out_stall) begin
        ox <= res_x;
        oy <= res_y;
        ov <= 1'b1;
      end else begin
        sx <= res_x;
        sy <= res_y;
        sv <= 1'b1;
      end
    end else if (!out_stall) begin
      ov <= 1'b0;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sv |-> ov)
    else $error("skid word held with output empty");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && out_stall))
    else $error("skid filled without a stalled output");

  a_result_delivered: assert property (@(posedge clk) disable iff (rst)
    (en && vld[PIPE_DEPTH-1]) |=> ov)
    else $error("finished word lost at the output");

endmodule
